[rtl/ump2m1_pkg.sv]
// Shared types and constants for the UMP to MIDI 1.0 event converter.
package ump2m1_pkg;

  // Packet message types
  localparam logic [3:0] MT_MIDI1 = 4'h2;
  localparam logic [3:0] MT_MIDI2 = 4'h4;
  localparam logic [3:0] MT_FLEX  = 4'hD;

  // Channel voice status codes
  localparam logic [3:0] ST_RPN      = 4'h2;
  localparam logic [3:0] ST_NRPN     = 4'h3;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY     = 4'hA;
  localparam logic [3:0] ST_CC       = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CPRESS   = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // Controller numbers
  localparam logic [7:0] CC_BANK_MSB = 8'd0;
  localparam logic [7:0] CC_BANK_LSB = 8'd32;
  localparam logic [7:0] CC_RPN_MSB  = 8'd101;
  localparam logic [7:0] CC_RPN_LSB  = 8'd100;
  localparam logic [7:0] CC_NRPN_MSB = 8'd99;
  localparam logic [7:0] CC_NRPN_LSB = 8'd98;
  localparam logic [7:0] CC_DATA_MSB = 8'd6;
  localparam logic [7:0] CC_DATA_LSB = 8'd38;

  // Flex data status
  localparam logic [7:0] FLEX_BANK_SETUP = 8'h00;
  localparam logic [7:0] FLEX_SET_TEMPO  = 8'h00;
  localparam logic [7:0] FLEX_TIME_SIG   = 8'h01;

  // Word count thresholds
  localparam logic [2:0] WC_MIDI1 = 3'd1;
  localparam logic [2:0] WC_MIDI2 = 3'd2;
  localparam logic [2:0] WC_FLEX  = 3'd4;

  // Tempo: round(x / 100) = ((x + 50) >> 2) / 25, the /25 by reciprocal
  localparam int unsigned TEMPO_W     = 26;
  localparam logic [32:0] TEMPO_ROUND = 33'd50;
  localparam logic [31:0] TEMPO_RECIP = 32'd2748779070;
  localparam int unsigned TEMPO_SHIFT = 36;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 26'd500000;

  // Job queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [3:0] {
    EVT_NOTE_OFF  = 4'd0,
    EVT_NOTE_ON   = 4'd1,
    EVT_POLYPRESS = 4'd2,
    EVT_CC        = 4'd3,
    EVT_PROGRAM   = 4'd4,
    EVT_CHANPRESS = 4'd5,
    EVT_BEND      = 4'd6,
    EVT_TEMPO     = 4'd7,
    EVT_TIMESIG   = 4'd8
  } evt_kind_e;

  typedef struct packed {
    evt_kind_e  kind;
    logic [7:0] d1;
    logic [7:0] d2;
  } evt_t;

  // One decoded packet: up to four events sharing channel, tempo and tick
  typedef struct packed {
    logic [1:0]         last_idx;
    logic [3:0]         chan;
    logic [TEMPO_W-1:0] tempo;
    logic [31:0]        tick;
    evt_t [3:0]         ev;
  } job_t;

endpackage

[rtl/ump_in_if.sv]
// Packet input channel: valid/ready handshake with UMP payload.
interface ump_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_count;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic [31:0] event_tick;

  modport source (output valid, word_count, first_word, second_word, event_tick,
                  input ready);
  modport sink (input valid, word_count, first_word, second_word, event_tick,
                output ready);
endinterface

[rtl/midi_ev_if.sv]
// Event output channel: valid/ready handshake with MIDI 1.0 event payload.
interface midi_ev_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [3:0]  channel_number;
  logic [7:0]  data_first;
  logic [7:0]  data_second;
  logic [25:0] tempo_micros;
  logic [31:0] out_tick;
  logic        last_of_run;

  modport source (output valid, event_kind, channel_number, data_first, data_second,
                  tempo_micros, out_tick, last_of_run, input ready);
  modport sink (input valid, event_kind, channel_number, data_first, data_second,
                tempo_micros, out_tick, last_of_run, output ready);
  modport monitor (input valid, ready, event_kind, channel_number, data_first,
                   data_second, tempo_micros, out_tick, last_of_run);
endinterface

[rtl/ump2m1_front.sv]
// Front end: accepts packets, classifies them and builds event jobs.
module ump2m1_front (
  ump_in_if.sink           ump_i,
  input  logic             full_i,
  output logic             push_o,
  output ump2m1_pkg::job_t job_o
);
  import ump2m1_pkg::*;

  logic [3:0]         mt, st, ch;
  logic [7:0]         i1, i2;
  logic [31:0]        w1;
  logic [6:0]         v7, lsb7;
  logic [32:0]        tempo_sum;
  logic [30:0]        tempo_quarter;
  logic [62:0]        tempo_prod;
  logic [TEMPO_W-1:0] tempo_us;
  logic               has_evt;
  job_t               job;

  assign mt   = ump_i.first_word[31:28];
  assign st   = ump_i.first_word[23:20];
  assign ch   = ump_i.first_word[19:16];
  assign i1   = ump_i.first_word[15:8];
  assign i2   = ump_i.first_word[7:0];
  assign w1   = ump_i.second_word;
  assign v7   = w1[31:25];
  assign lsb7 = w1[24:18];

  // Rounded 10 ns to microsecond conversion
  assign tempo_sum     = {1'b0, w1} + TEMPO_ROUND;
  assign tempo_quarter = tempo_sum[32:2];
  assign tempo_prod    = tempo_quarter * TEMPO_RECIP;
  assign tempo_us      = (w1 == '0) ? TEMPO_DEFAULT
                                    : tempo_prod[TEMPO_SHIFT +: TEMPO_W];

  always_comb begin
    job      = '0;
    has_evt  = 1'b0;
    job.tick = ump_i.event_tick;
    job.chan = ch;
    if (ump_i.word_count >= WC_MIDI1) begin
      unique case (mt)
        MT_MIDI1: begin
          if (st[3] && st != ST_SYSTEM) begin
            has_evt      = 1'b1;
            job.ev[0].kind = evt_kind_e'({1'b0, st[2:0]});
            job.ev[0].d1 = {1'b0, i1[6:0]};
            job.ev[0].d2 = {1'b0, i2[6:0]};
            if (st == ST_NOTE_ON && i2[6:0] == '0) job.ev[0].kind = EVT_NOTE_OFF;
          end
        end
        MT_MIDI2: begin
          if (ump_i.word_count >= WC_MIDI2) begin
            has_evt = 1'b1;
            unique case (st)
              ST_NOTE_OFF, ST_NOTE_ON: begin
                job.ev[0].kind = (st == ST_NOTE_ON && v7 != '0) ? EVT_NOTE_ON
                                                                : EVT_NOTE_OFF;
                job.ev[0].d1 = i1;
                job.ev[0].d2 = {1'b0, v7};
              end
              ST_POLY: begin
                job.ev[0] = '{kind: EVT_POLYPRESS, d1: i1, d2: {1'b0, v7}};
              end
              ST_CC: begin
                job.ev[0] = '{kind: EVT_CC, d1: i1, d2: {1'b0, v7}};
              end
              ST_PROG: begin
                if (i2[0]) begin
                  job.ev[0]    = '{kind: EVT_CC, d1: CC_BANK_MSB, d2: w1[15:8]};
                  job.ev[1]    = '{kind: EVT_CC, d1: CC_BANK_LSB, d2: w1[7:0]};
                  job.ev[2]    = '{kind: EVT_PROGRAM, d1: w1[31:24], d2: 8'd0};
                  job.last_idx = 2'd2;
                end else begin
                  job.ev[0] = '{kind: EVT_PROGRAM, d1: w1[31:24], d2: 8'd0};
                end
              end
              ST_CPRESS: begin
                job.ev[0] = '{kind: EVT_CHANPRESS, d1: {1'b0, v7}, d2: 8'd0};
              end
              ST_BEND: begin
                job.ev[0] = '{kind: EVT_BEND, d1: {1'b0, lsb7}, d2: {1'b0, v7}};
              end
              ST_RPN, ST_NRPN: begin
                job.ev[0] = '{kind: EVT_CC,
                              d1: (st == ST_RPN) ? CC_RPN_MSB : CC_NRPN_MSB, d2: i1};
                job.ev[1] = '{kind: EVT_CC,
                              d1: (st == ST_RPN) ? CC_RPN_LSB : CC_NRPN_LSB, d2: i2};
                job.ev[2] = '{kind: EVT_CC, d1: CC_DATA_MSB, d2: {1'b0, v7}};
                job.ev[3] = '{kind: EVT_CC, d1: CC_DATA_LSB, d2: {1'b0, lsb7}};
                job.last_idx = 2'd3;
              end
              default: has_evt = 1'b0;
            endcase
          end
        end
        MT_FLEX: begin
          job.chan = '0;
          if (ump_i.word_count >= WC_FLEX && i1 == FLEX_BANK_SETUP) begin
            if (i2 == FLEX_SET_TEMPO) begin
              has_evt        = 1'b1;
              job.ev[0].kind = EVT_TEMPO;
              job.tempo      = tempo_us;
            end else if (i2 == FLEX_TIME_SIG) begin
              has_evt        = 1'b1;
              job.ev[0].kind = EVT_TIMESIG;
            end
          end
        end
        default: has_evt = 1'b0;
      endcase
    end
  end

  assign ump_i.ready = !full_i;
  assign push_o      = ump_i.valid && !full_i && has_evt;
  assign job_o       = job;

endmodule

[rtl/ump2m1_queue.sv]
// Short job queue between front end and event sequencer.
module ump2m1_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ump2m1_pkg::job_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output ump2m1_pkg::job_t head_o
);
  import ump2m1_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[rtl/ump2m1_back.sv]
// Back end: steps through the events of each job into the output register.
module ump2m1_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ump2m1_pkg::job_t head_i,
  output logic             pop_o,
  midi_ev_if.source        evt_o
);
  import ump2m1_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic               valid_q, valid_d;
  logic               load, last;
  evt_t               cur;
  logic [3:0]         kind_q;
  logic [3:0]         chan_q;
  logic [7:0]         d1_q, d2_q;
  logic [TEMPO_W-1:0] tempo_q;
  logic [31:0]        tick_q;
  logic               last_q;

  assign cur  = head_i.ev[idx_q];
  assign last = (idx_q == head_i.last_idx);
  // Refill the output register whenever it is empty or being drained
  assign load  = !empty_i && (!valid_q || evt_o.ready);
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    if (load) idx_d = last ? 2'd0 : idx_q + 2'd1;
    valid_d = load || (valid_q && !evt_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= cur.kind;
      chan_q  <= head_i.chan;
      d1_q    <= cur.d1;
      d2_q    <= cur.d2;
      tempo_q <= head_i.tempo;
      tick_q  <= head_i.tick;
      last_q  <= last;
    end
  end

  assign evt_o.valid          = valid_q;
  assign evt_o.event_kind     = kind_q;
  assign evt_o.channel_number = chan_q;
  assign evt_o.data_first     = d1_q;
  assign evt_o.data_second    = d2_q;
  assign evt_o.tempo_micros   = tempo_q;
  assign evt_o.out_tick       = tick_q;
  assign evt_o.last_of_run    = last_q;

endmodule

[rtl/ump_to_midi1_event_converter.sv]
// Top level of the UMP to MIDI 1.0 event converter.
// Accepts one Universal MIDI Packet per cycle while its two-entry job queue
// has room, and delivers one MIDI 1.0 event per cycle while the sink is
// ready; a packet that expands to k events (k = 0..4) sends them out one after
// another, and the output port is what sets the sustained rate. The first
// event of a packet passes through the job queue and the output register
// before it is presented, and waits while earlier events hold the output.
// Packets with no events are consumed and leave nothing behind. Set-tempo
// values are rounded to microseconds with one constant-reciprocal multiply
// in the front end, and every event carries its packet's timestamp;
// last_of_run marks the final event of each packet. Reset empties the queue
// and the output stage.
module ump_to_midi1_event_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  ump_in_if.sink    ump_i,
  midi_ev_if.source evt_o
);
  import ump2m1_pkg::*;

  logic push, pop, full, empty;
  job_t push_job, head_job;

  ump2m1_front u_front (
    .ump_i  (ump_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  ump2m1_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head_job)
  );

  ump2m1_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_job),
    .pop_o   (pop),
    .evt_o   (evt_o)
  );

endmodule

[rtl/ump2m1_checker.sv]
// Port-level checks for the converter, bound to the top level.
module ump2m1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        evt_valid_i,
  input logic        evt_ready_i,
  input logic [3:0]  event_kind_i,
  input logic [3:0]  channel_number_i,
  input logic [7:0]  data_first_i,
  input logic [7:0]  data_second_i,
  input logic [25:0] tempo_micros_i,
  input logic [31:0] out_tick_i,
  input logic        last_of_run_i
);
  import ump2m1_pkg::*;

  // Hold a stalled event
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i && $stable(event_kind_i)
      && $stable(data_first_i) && $stable(data_second_i)
      && $stable(out_tick_i) && $stable(last_of_run_i))
    else $error("stalled event changed");

  // The rest of a packet follows without a gap and keeps its timestamp
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i && !last_of_run_i
      |=> evt_valid_i && out_tick_i == $past(out_tick_i)
        && channel_number_i == $past(channel_number_i))
    else $error("packet run broken");

  // Tempo only on tempo events
  a_tempo_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && event_kind_i != EVT_TEMPO |-> tempo_micros_i == '0)
    else $error("tempo on non-tempo event");

  // Flex events are single, channel zero, no data
  a_flex_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (event_kind_i == EVT_TEMPO || event_kind_i == EVT_TIMESIG)
      |-> last_of_run_i && channel_number_i == '0
        && data_first_i == '0 && data_second_i == '0)
    else $error("malformed flex event");

endmodule

bind ump_to_midi1_event_converter ump2m1_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .evt_valid_i      (evt_o.valid),
  .evt_ready_i      (evt_o.ready),
  .event_kind_i     (evt_o.event_kind),
  .channel_number_i (evt_o.channel_number),
  .data_first_i     (evt_o.data_first),
  .data_second_i    (evt_o.data_second),
  .tempo_micros_i   (evt_o.tempo_micros),
  .out_tick_i       (evt_o.out_tick),
  .last_of_run_i    (evt_o.last_of_run)
);

[test/tb_ump_to_midi1_event_converter.sv]
// Testbench for the UMP to MIDI 1.0 event converter: random packets, scoreboard checks.
module tb_ump_to_midi1_event_converter;
  import ump2m1_pkg::*;

  typedef struct packed {
    evt_kind_e          kind;
    logic [3:0]         chan;
    logic [7:0]         d1;
    logic [7:0]         d2;
    logic [TEMPO_W-1:0] tempo;
    logic [31:0]        tick;
    logic               last;
  } midi_event_t;

  class midi_scoreboard;
    midi_event_t expected_events[$];
    midi_event_t packet_events[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    function void add_event(evt_kind_e kind, logic [3:0] chan, logic [7:0] d1,
                            logic [7:0] d2, logic [TEMPO_W-1:0] tempo,
                            logic [31:0] tick);
      midi_event_t ev;
      ev.kind  = kind;
      ev.chan  = chan;
      ev.d1    = d1;
      ev.d2    = d2;
      ev.tempo = tempo;
      ev.tick  = tick;
      ev.last  = 1'b0;
      packet_events.insert(packet_events.size(), ev);
    endfunction

    // Translate one accepted packet into the events it must produce.
    function void note_packet(logic [2:0] wc, logic [31:0] w0, logic [31:0] w1,
                              logic [31:0] tick);
      logic [3:0]  mt;
      logic [3:0]  st;
      logic [3:0]  chan;
      logic [7:0]  idx1;
      logic [7:0]  idx2;
      logic [6:0]  v7;
      logic [32:0] rounded;
      evt_kind_e   kind;
      mt   = w0[31:28];
      st   = w0[23:20];
      chan = w0[19:16];
      idx1 = w0[15:8];
      idx2 = w0[7:0];
      v7   = w1[31:25];
      packet_events.delete();
      if (wc >= WC_MIDI1 && mt == MT_MIDI1) begin
        if (st >= ST_NOTE_OFF && st <= ST_BEND) begin
          kind = evt_kind_e'(st - ST_NOTE_OFF);
          if (kind == EVT_NOTE_ON && idx2[6:0] == 7'd0) kind = EVT_NOTE_OFF;
          add_event(kind, chan, {1'b0, idx1[6:0]}, {1'b0, idx2[6:0]}, '0, tick);
        end
      end else if (wc >= WC_MIDI2 && mt == MT_MIDI2) begin
        case (st)
          ST_NOTE_OFF, ST_NOTE_ON: begin
            kind = (st == ST_NOTE_ON && v7 != 7'd0) ? EVT_NOTE_ON : EVT_NOTE_OFF;
            add_event(kind, chan, idx1, {1'b0, v7}, '0, tick);
          end
          ST_POLY:   add_event(EVT_POLYPRESS, chan, idx1, {1'b0, v7}, '0, tick);
          ST_CC:     add_event(EVT_CC, chan, idx1, {1'b0, v7}, '0, tick);
          ST_PROG: begin
            // Bank select goes out ahead of the program change.
            if (idx2[0]) begin
              add_event(EVT_CC, chan, CC_BANK_MSB, w1[15:8], '0, tick);
              add_event(EVT_CC, chan, CC_BANK_LSB, w1[7:0], '0, tick);
            end
            add_event(EVT_PROGRAM, chan, w1[31:24], 8'd0, '0, tick);
          end
          ST_CPRESS: add_event(EVT_CHANPRESS, chan, {1'b0, v7}, 8'd0, '0, tick);
          ST_BEND:   add_event(EVT_BEND, chan, {1'b0, w1[24:18]}, {1'b0, w1[31:25]}, '0, tick);
          ST_RPN, ST_NRPN: begin
            add_event(EVT_CC, chan, (st == ST_RPN) ? CC_RPN_MSB : CC_NRPN_MSB, idx1, '0, tick);
            add_event(EVT_CC, chan, (st == ST_RPN) ? CC_RPN_LSB : CC_NRPN_LSB, idx2, '0, tick);
            add_event(EVT_CC, chan, CC_DATA_MSB, {1'b0, v7}, '0, tick);
            add_event(EVT_CC, chan, CC_DATA_LSB, {1'b0, w1[24:18]}, '0, tick);
          end
          default: ;
        endcase
      end else if (wc >= WC_FLEX && mt == MT_FLEX && idx1 == FLEX_BANK_SETUP) begin
        if (idx2 == FLEX_SET_TEMPO) begin
          rounded = ({1'b0, w1} + TEMPO_ROUND) / 33'd100;
          add_event(EVT_TEMPO, 4'd0, 8'd0, 8'd0,
                    (w1 == 32'd0) ? TEMPO_DEFAULT : rounded[TEMPO_W-1:0], tick);
        end else if (idx2 == FLEX_TIME_SIG) begin
          add_event(EVT_TIMESIG, 4'd0, 8'd0, 8'd0, '0, tick);
        end
      end
      if (packet_events.size() != 0) packet_events[packet_events.size() - 1].last = 1'b1;
      expected_events = {expected_events, packet_events};
    endfunction

    function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_event(midi_event_t got);
      midi_event_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual kind %0d ch %0d d1 %0h d2 %0h",
                 $time, got.kind, got.chan, got.d1, got.d2);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      report("event_kind", want.kind, got.kind);
      report("channel_number", want.chan, got.chan);
      report("data_first", want.d1, got.d1);
      report("data_second", want.d2, got.d2);
      report("tempo_micros", want.tempo, got.tempo);
      report("out_tick", want.tick, got.tick);
      report("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ump_in_if  ump_bus ();
  midi_ev_if evt_bus ();

  ump_to_midi1_event_converter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ump_i  (ump_bus),
    .evt_o  (evt_bus)
  );

  midi_scoreboard sb;
  bit send_burst;
  bit recv_burst;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    midi_event_t got;
    if (rst_ni) begin
      if (ump_bus.valid && ump_bus.ready)
        sb.note_packet(ump_bus.word_count, ump_bus.first_word, ump_bus.second_word,
                       ump_bus.event_tick);
      if (evt_bus.valid && evt_bus.ready) begin
        got.kind  = evt_kind_e'(evt_bus.event_kind);
        got.chan  = evt_bus.channel_number;
        got.d1    = evt_bus.data_first;
        got.d2    = evt_bus.data_second;
        got.tempo = evt_bus.tempo_micros;
        got.tick  = evt_bus.out_tick;
        got.last  = evt_bus.last_of_run;
        sb.check_event(got);
      end
    end
  end

  task automatic send_packet(input logic [2:0] wc, input logic [31:0] w0,
                             input logic [31:0] w1, input logic [31:0] tick);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      ump_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ump_bus.valid       <= 1'b1;
    ump_bus.word_count  <= wc;
    ump_bus.first_word  <= w0;
    ump_bus.second_word <= w1;
    ump_bus.event_tick  <= tick;
    do @(posedge clk_i); while (!ump_bus.ready);
  endtask

  // Hold the input idle until every predicted event has come out.
  task automatic wait_for_drain();
    ump_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic random_packet(output logic [2:0] wc, output logic [31:0] w0,
                               output logic [31:0] w1);
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    w0   = $urandom;
    w1   = $urandom;
    case ($urandom_range(0, 15))
      0: w1 = '0;
      1: w1 = '1;
      default: ;
    endcase
    if (pick < 30) begin
      wc         = 3'($urandom_range(1, 4));
      w0[31:28]  = MT_MIDI1;
      w0[23:20]  = 4'($urandom_range(ST_NOTE_OFF, ST_BEND));
      if ($urandom_range(0, 7) == 0) w0[6:0] = '0;
    end else if (pick < 75) begin
      wc        = 3'($urandom_range(2, 4));
      w0[31:28] = MT_MIDI2;
      sel       = $urandom_range(0, 8);
      case (sel)
        0:       w0[23:20] = ST_RPN;
        1:       w0[23:20] = ST_NRPN;
        default: w0[23:20] = ST_NOTE_OFF + 4'(sel - 2);
      endcase
      // Push some note-ons down to zero scaled velocity.
      if ($urandom_range(0, 7) == 0) w1[31:25] = '0;
    end else if (pick < 90) begin
      wc        = 3'd4;
      w0[31:28] = MT_FLEX;
      if ($urandom_range(0, 7) != 0) w0[15:8] = FLEX_BANK_SETUP;
      if ($urandom_range(0, 7) != 0)
        w0[7:0] = $urandom_range(0, 1) ? FLEX_SET_TEMPO : FLEX_TIME_SIG;
    end else begin
      wc = 3'($urandom_range(0, 4));
    end
  endtask

  initial begin
    evt_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      int unsigned stall;
      int unsigned taken;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        evt_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      evt_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!evt_bus.valid);
      taken++;
      if (taken % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [2:0]  wc;
    logic [31:0] w0;
    logic [31:0] w1;
    sb = new();
    send_burst = 1'b0;
    recv_burst = 1'b0;
    ump_bus.valid       <= 1'b0;
    ump_bus.word_count  <= '0;
    ump_bus.first_word  <= '0;
    ump_bus.second_word <= '0;
    ump_bus.event_tick  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // MIDI 1.0 voice: masking to 7 bits, zero-velocity note-on, program
    send_packet(3'd1, {MT_MIDI1, 4'hF, ST_NOTE_ON, 4'hF, 8'hFF, 8'hFF}, '1, '1);
    send_packet(3'd1, {MT_MIDI1, 4'h0, ST_NOTE_ON, 4'h0, 8'h3C, 8'h80}, '0, '0);
    send_packet(3'd4, {MT_MIDI1, 4'h2, ST_PROG, 4'h9, 8'h85, 8'h00}, $urandom, $urandom);
    // Dropped: no words, system status, MIDI 2.0 with one word
    send_packet(3'd0, {MT_MIDI1, 4'h0, ST_CC, 4'h1, 8'h07, 8'h40}, '0, $urandom);
    send_packet(3'd1, {MT_MIDI1, 4'h0, ST_SYSTEM, 4'h1, 8'h07, 8'h40}, '0, $urandom);
    send_packet(3'd1, {MT_MIDI2, 4'h0, ST_NOTE_ON, 4'h1, 8'h40, 8'h00}, '1, $urandom);
    // MIDI 2.0 voice: note-on, poly, CC, program, pressure, bend, RPN, NRPN, unknown
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_NOTE_ON, 4'h3, 8'h40, 8'h00}, 32'h01FF_FFFF, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'hF, ST_NOTE_ON, 4'hF, 8'hFF, 8'hFF}, 32'hFFFF_0000, '1);
    send_packet(3'd3, {MT_MIDI2, 4'h1, ST_POLY, 4'h4, 8'h80, 8'h00}, 32'hFE00_0000, $urandom);
    send_packet(3'd4, {MT_MIDI2, 4'h1, ST_CC, 4'h5, 8'h80, 8'h00}, $urandom, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_PROG, 4'h6, 8'h00, 8'hFE}, $urandom, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_PROG, 4'h7, 8'h00, 8'h01}, $urandom, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_CPRESS, 4'h8, 8'h00, 8'h00}, $urandom, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_BEND, 4'h9, 8'h00, 8'h00}, '1, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, ST_RPN, 4'hA, 8'hAA, 8'h55}, $urandom, $urandom);
    send_packet(3'd4, {MT_MIDI2, 4'h0, ST_NRPN, 4'hB, 8'h55, 8'hAA}, $urandom, $urandom);
    send_packet(3'd2, {MT_MIDI2, 4'h0, 4'h0, 4'hC, 8'h12, 8'h34}, $urandom, $urandom);
    // Flex data: short packet, tempo extremes and rounding, time signature, bad bank
    send_packet(3'd3, {MT_FLEX, 4'h0, 4'h1, 4'h0, FLEX_BANK_SETUP, FLEX_SET_TEMPO}, 32'd100, 0);
    send_packet(3'd4, {MT_FLEX, 4'h0, 4'h1, 4'h0, FLEX_BANK_SETUP, FLEX_SET_TEMPO}, '0, $urandom);
    send_packet(3'd4, {MT_FLEX, 4'h0, 4'h1, 4'h0, FLEX_BANK_SETUP, FLEX_SET_TEMPO}, '1, $urandom);
    send_packet(3'd4, {MT_FLEX, 4'h0, 4'h1, 4'h0, FLEX_BANK_SETUP, FLEX_SET_TEMPO}, 32'd149, 0);
    send_packet(3'd4, {MT_FLEX, 4'h0, 4'h1, 4'h0, FLEX_BANK_SETUP, FLEX_TIME_SIG}, $urandom, 0);
    send_packet(3'd4, {MT_FLEX, 4'h0, 4'h1, 4'h0, 8'h01, FLEX_SET_TEMPO}, 32'd500, $urandom);
    wait_for_drain();

    for (int i = 0; i < 187; i++) begin
      if (i % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (i == 110) wait_for_drain();
      random_packet(wc, w0, w1);
      send_packet(wc, w0, w1, $urandom);
    end

    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
